// ===== sv/dmij_pkg.sv =====
`default_nettype none

package dmij_pkg;

    localparam int DMI_WIDTH    = 41;
    localparam int DTMCS_WIDTH  = 32;
    localparam int ADDR_BITS    = 7;

    localparam int OP_W         = 2;
    localparam int ADDR_W       = 7;
    localparam int DATA_W       = 32;
    localparam int CNT_W        = 9;
    localparam int IR_W         = 5;
    localparam int IRLEN_W      = 5;
    localparam int IDLE_W       = 8;
    localparam int DMI_ADDR_POS = 34;
    localparam int WORD_W       = DMI_ADDR_POS + ADDR_W;

    localparam logic [IR_W-1:0]   IR_DTMCS  = 5'h10;
    localparam logic [IR_W-1:0]   IR_DMI    = 5'h11;
    localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_IR_LENGTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_TICKS = 2'd1;

    localparam logic [IRLEN_W-1:0] IR_LENGTH_RST  = 5'd5;
    localparam logic [IDLE_W-1:0]  IDLE_TICKS_RST = 8'd5;

    typedef enum logic [2:0] {
        P_INIT, P_WAIT, P_POLL1, P_SEND, P_POLL2, P_GAP, P_READ, P_DONE
    } t_phase;

    typedef enum logic [3:0] {
        T_TLR, T_RTI, T_SELDR, T_SELIR, T_CAPIR, T_SHIR, T_EX1IR, T_UPDIR,
        T_CAPDR, T_SHDR, T_EX1DR, T_UPDDR
    } t_tap;

    typedef enum logic {
        K_TICK, K_REQ
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic                tdo;
        logic [OP_W-1:0]     op;
        logic [ADDR_W-1:0]   addr;
        logic [DATA_W-1:0]   data;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_src;

endpackage

`default_nettype wire

// ===== sv/dmij_if.sv =====
`default_nettype none

interface dmij_in_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic                        tdo;
    logic [dmij_pkg::OP_W-1:0]   req_op;
    logic [dmij_pkg::ADDR_W-1:0] req_addr;
    logic [dmij_pkg::DATA_W-1:0] req_data;

    modport source (output valid, action, tdo, req_op, req_addr, req_data, input ready);
    modport sink   (input valid, action, tdo, req_op, req_addr, req_data, output ready);
endinterface

interface dmij_out_if;
    logic                        valid;
    logic                        ready;
    logic                        tck;
    logic                        tms;
    logic                        tdi;
    logic                        trst_n;
    logic                        req_taken;
    logic                        resp_valid;
    logic                        resp_error;
    logic [dmij_pkg::DATA_W-1:0] resp_data;

    modport source (output valid, tck, tms, tdi, trst_n, req_taken, resp_valid, resp_error,
                    resp_data, input ready);
    modport sink   (input valid, tck, tms, tdi, trst_n, req_taken, resp_valid, resp_error,
                    resp_data, output ready);
endinterface

interface dmij_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [dmij_pkg::CFG_IDX_W-1:0]  index;
    logic [dmij_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/dmij_front.sv =====
`default_nettype none

module dmij_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dmij_in_if.sink         i_item,
    input  logic            i_pop,
    output dmij_pkg::t_q_src o_q
);

    localparam int DEPTH = 2;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QCNT_W = $clog2(DEPTH + 1);

    dmij_pkg::t_item   r_slot [DEPTH];
    logic [PTR_W-1:0]  r_wptr, n_wptr;
    logic [PTR_W-1:0]  r_rptr, n_rptr;
    logic [QCNT_W-1:0] r_count, n_count;
    dmij_pkg::t_item   w_item;
    logic              w_push;

    assign i_item.ready = (r_count != QCNT_W'(DEPTH));
    assign w_push       = i_item.valid && i_item.ready;

    // ticks carry only tdo; requests carry the masked request fields
    always_comb begin
        w_item      = '0;
        w_item.tdo  = i_item.tdo;
        w_item.kind = i_item.action ? dmij_pkg::K_REQ : dmij_pkg::K_TICK;
        if (i_item.action) begin
            w_item.op   = i_item.req_op;
            w_item.addr = i_item.req_addr & dmij_pkg::ADDR_MASK;
            w_item.data = i_item.req_data;
        end
    end

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        if (w_push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
        end
        n_count = r_count + QCNT_W'(w_push) - QCNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wptr] <= w_item;
        end
    end

    assign o_q.valid = (r_count != '0);
    assign o_q.item  = r_slot[r_rptr];

endmodule

`default_nettype wire

// ===== sv/dmij_back.sv =====
`default_nettype none

module dmij_back #(
    parameter int DMI_WIDTH = dmij_pkg::DMI_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dmij_pkg::t_q_src i_q,
    output logic             o_pop,
    dmij_cfg_if.sink         i_cfg,
    dmij_out_if.source       o_resp
);

    localparam int IDX_W    = $clog2(DMI_WIDTH);
    localparam int IR_IDX_W = $clog2(dmij_pkg::IR_W);
    localparam int WIDX_W   = $clog2(dmij_pkg::WORD_W);
    localparam int CNT_W    = dmij_pkg::CNT_W;
    localparam logic [6:0] DR_DTMCS = 7'(dmij_pkg::DTMCS_WIDTH);
    localparam logic [6:0] DR_DMI   = 7'(DMI_WIDTH);

    logic [dmij_pkg::IRLEN_W-1:0] r_ir_length;
    logic [dmij_pkg::IDLE_W-1:0]  r_idle_ticks;

    dmij_pkg::t_phase            r_phase, n_phase;
    dmij_pkg::t_tap              r_tap, n_tap;
    dmij_pkg::t_tap              r_tap_prev, n_tap_prev;
    logic [CNT_W-1:0]            r_tick, n_tick;
    logic [DMI_WIDTH-1:0]        r_tdo_shift, n_tdo_shift;
    logic [dmij_pkg::OP_W-1:0]   r_held_op, n_held_op;
    logic [dmij_pkg::ADDR_W-1:0] r_held_addr, n_held_addr;
    logic [dmij_pkg::DATA_W-1:0] r_held_data, n_held_data;
    logic                        r_tck, n_tck;
    logic                        r_tms, n_tms;
    logic                        r_tdi, n_tdi;

    logic                        r_out_valid;
    logic                        r_o_tck, r_o_tms, r_o_tdi;
    logic                        r_o_taken, r_o_rvalid, r_o_rerror;
    logic [dmij_pkg::DATA_W-1:0] r_o_rdata;

    logic                        w_pop;
    logic                        w_tick;
    logic                        w_poll;
    logic [dmij_pkg::IR_W-1:0]   w_inst;
    logic [6:0]                  w_dr_width;
    logic [dmij_pkg::WORD_W-1:0] w_wdata;
    logic [dmij_pkg::IRLEN_W-1:0] w_len;
    logic [CNT_W:0]              w_tick_inc;
    logic [7:0]                  w_idx;

    logic [CNT_W:0]              a_limit;
    logic                        a_tms, a_tdi, a_fin, a_bump, a_done;
    dmij_pkg::t_tap              a_next;
    logic [DMI_WIDTH-1:0]        a_shift;
    logic [CNT_W-1:0]            a_tick;

    logic [CNT_W:0]              w_init_limit;
    logic                        w_init_bump;

    logic                        w_taken, w_rvalid, w_rerror;
    logic [dmij_pkg::DATA_W-1:0] w_rdata;

    assign w_pop = i_q.valid && (!r_out_valid || o_resp.ready);
    assign o_pop = w_pop;
    assign w_tick = (i_q.item.kind == dmij_pkg::K_TICK);

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ir_length  <= dmij_pkg::IR_LENGTH_RST;
            r_idle_ticks <= dmij_pkg::IDLE_TICKS_RST;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == dmij_pkg::REG_IR_LENGTH) begin
                r_ir_length <= i_cfg.data[dmij_pkg::IRLEN_W-1:0];
            end
            if (i_cfg.index == dmij_pkg::REG_IDLE_TICKS) begin
                r_idle_ticks <= i_cfg.data[dmij_pkg::IDLE_W-1:0];
            end
        end
    end

    // access parameters for the current phase
    assign w_poll     = (r_phase == dmij_pkg::P_POLL1) || (r_phase == dmij_pkg::P_POLL2);
    assign w_inst     = w_poll ? dmij_pkg::IR_DTMCS : dmij_pkg::IR_DMI;
    assign w_dr_width = w_poll ? DR_DTMCS : DR_DMI;
    assign w_wdata    = (r_phase == dmij_pkg::P_SEND) ?
                        {r_held_addr, r_held_data, r_held_op} : '0;
    assign w_len      = (r_ir_length == '0) ? dmij_pkg::IRLEN_W'(1) : r_ir_length;
    assign w_tick_inc = {1'b0, r_tick} + (CNT_W+1)'(1);
    assign w_idx      = r_tick[CNT_W-1:1];

    // one half clock of a TAP walk
    always_comb begin
        a_limit = (CNT_W+1)'(2);
        a_tms   = 1'b0;
        a_tdi   = 1'b0;
        a_fin   = 1'b0;
        a_next  = r_tap;
        a_shift = r_tdo_shift;
        unique case (r_tap)
            dmij_pkg::T_RTI: begin
                a_tms  = 1'b1;
                a_next = dmij_pkg::T_SELDR;
            end
            dmij_pkg::T_SELDR: begin
                if (r_tap_prev == dmij_pkg::T_UPDIR) begin
                    a_next = dmij_pkg::T_CAPDR;
                end else begin
                    a_tms  = 1'b1;
                    a_next = dmij_pkg::T_SELIR;
                end
            end
            dmij_pkg::T_SELIR: a_next = dmij_pkg::T_CAPIR;
            dmij_pkg::T_CAPIR: a_next = dmij_pkg::T_SHIR;
            dmij_pkg::T_SHIR: begin
                a_limit = {4'd0, w_len, 1'b0};
                a_tms   = (r_tick >= {3'd0, w_len - dmij_pkg::IRLEN_W'(1), 1'b0});
                a_tdi   = (w_idx < 8'(dmij_pkg::IR_W)) ? w_inst[w_idx[IR_IDX_W-1:0]] : 1'b0;
                a_next  = dmij_pkg::T_EX1IR;
            end
            dmij_pkg::T_EX1IR: begin
                a_tms  = 1'b1;
                a_next = dmij_pkg::T_UPDIR;
            end
            dmij_pkg::T_UPDIR: begin
                a_tms  = 1'b1;
                a_next = dmij_pkg::T_SELDR;
            end
            dmij_pkg::T_CAPDR: a_next = dmij_pkg::T_SHDR;
            dmij_pkg::T_SHDR: begin
                if (r_tick == '0) begin
                    a_shift = '0;
                end
                a_limit = {2'd0, w_dr_width, 1'b0};
                a_tms   = (r_tick >= {1'b0, w_dr_width - 7'd1, 1'b0});
                a_tdi   = (w_idx < 8'(dmij_pkg::WORD_W)) ? w_wdata[w_idx[WIDX_W-1:0]] : 1'b0;
                if (r_tick[0] && (w_idx < 8'(DMI_WIDTH))) begin
                    a_shift[w_idx[IDX_W-1:0]] = a_shift[w_idx[IDX_W-1:0]] | i_q.item.tdo;
                end
                a_next  = dmij_pkg::T_EX1DR;
            end
            dmij_pkg::T_EX1DR: begin
                a_tms  = 1'b1;
                a_next = dmij_pkg::T_UPDDR;
            end
            dmij_pkg::T_UPDDR: begin
                a_fin  = 1'b1;
                a_next = dmij_pkg::T_RTI;
            end
            default: a_next = dmij_pkg::T_RTI;
        endcase
        a_bump = (w_tick_inc >= a_limit);
        a_tick = a_bump ? '0 : w_tick_inc[CNT_W-1:0];
        a_done = a_bump && a_fin;
    end

    assign w_init_limit = {({1'b0, r_idle_ticks} + 9'd1), 1'b0};
    assign w_init_bump  = (w_tick_inc >= w_init_limit);

    // result fields
    always_comb begin
        w_taken  = !w_tick && (r_phase == dmij_pkg::P_WAIT);
        w_rvalid = w_tick && (r_phase == dmij_pkg::P_READ) && a_done;
        w_rerror = w_rvalid && (r_tdo_shift[1:0] != 2'd0);
        w_rdata  = w_rvalid ? r_tdo_shift[dmij_pkg::DATA_W+1:2] : '0;
    end

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_tap       = r_tap;
        n_tap_prev  = r_tap_prev;
        n_tick      = r_tick;
        n_tdo_shift = r_tdo_shift;
        n_held_op   = r_held_op;
        n_held_addr = r_held_addr;
        n_held_data = r_held_data;
        n_tck       = r_tck;
        n_tms       = r_tms;
        n_tdi       = r_tdi;
        if (!w_tick) begin
            if (r_phase == dmij_pkg::P_WAIT) begin
                n_held_op   = i_q.item.op;
                n_held_addr = i_q.item.addr;
                n_held_data = i_q.item.data;
                n_phase     = dmij_pkg::P_POLL1;
            end
        end else begin
            unique case (r_phase)
                dmij_pkg::P_INIT: begin
                    n_tck  = ~r_tck;
                    n_tms  = (r_tick < CNT_W'(2));
                    n_tdi  = 1'b0;
                    n_tick = w_init_bump ? '0 : w_tick_inc[CNT_W-1:0];
                    if (w_init_bump) begin
                        n_tap_prev = r_tap;
                        n_tap      = dmij_pkg::T_RTI;
                        n_phase    = dmij_pkg::P_WAIT;
                    end
                end
                dmij_pkg::P_WAIT: begin
                end
                dmij_pkg::P_POLL1, dmij_pkg::P_POLL2, dmij_pkg::P_SEND,
                dmij_pkg::P_READ: begin
                    n_tck       = ~r_tck;
                    n_tms       = a_tms;
                    n_tdi       = a_tdi;
                    n_tick      = a_tick;
                    n_tdo_shift = a_shift;
                    if (a_bump) begin
                        n_tap_prev = r_tap;
                        n_tap      = a_next;
                    end
                    if (a_done) begin
                        unique case (r_phase)
                            dmij_pkg::P_POLL1: begin
                                if (r_tdo_shift[11:10] == 2'd0) begin
                                    n_phase = dmij_pkg::P_SEND;
                                end
                            end
                            dmij_pkg::P_POLL2: begin
                                if (r_tdo_shift[11:10] == 2'd0) begin
                                    n_phase = dmij_pkg::P_GAP;
                                end
                            end
                            dmij_pkg::P_SEND: n_phase = dmij_pkg::P_POLL2;
                            default:          n_phase = dmij_pkg::P_DONE;
                        endcase
                    end
                end
                dmij_pkg::P_GAP:  n_phase = dmij_pkg::P_READ;
                default:          n_phase = dmij_pkg::P_WAIT;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= dmij_pkg::P_INIT;
            r_tap       <= dmij_pkg::T_TLR;
            r_tap_prev  <= dmij_pkg::T_TLR;
            r_tick      <= '0;
            r_tdo_shift <= '0;
            r_held_op   <= '0;
            r_held_addr <= '0;
            r_held_data <= '0;
            r_tck       <= 1'b1;
            r_tms       <= 1'b1;
            r_tdi       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (w_pop) begin
                r_phase     <= n_phase;
                r_tap       <= n_tap;
                r_tap_prev  <= n_tap_prev;
                r_tick      <= n_tick;
                r_tdo_shift <= n_tdo_shift;
                r_held_op   <= n_held_op;
                r_held_addr <= n_held_addr;
                r_held_data <= n_held_data;
                r_tck       <= n_tck;
                r_tms       <= n_tms;
                r_tdi       <= n_tdi;
                r_out_valid <= 1'b1;
            end else if (o_resp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_o_tck    <= n_tck;
            r_o_tms    <= n_tms;
            r_o_tdi    <= n_tdi;
            r_o_taken  <= w_taken;
            r_o_rvalid <= w_rvalid;
            r_o_rerror <= w_rerror;
            r_o_rdata  <= w_rdata;
        end
    end

    assign o_resp.valid      = r_out_valid;
    assign o_resp.tck        = r_o_tck;
    assign o_resp.tms        = r_o_tms;
    assign o_resp.tdi        = r_o_tdi;
    assign o_resp.trst_n     = 1'b1;
    assign o_resp.req_taken  = r_o_taken;
    assign o_resp.resp_valid = r_o_rvalid;
    assign o_resp.resp_error = r_o_rerror;
    assign o_resp.resp_data  = r_o_rdata;

endmodule

`default_nettype wire

// ===== sv/dmi_over_jtag_master_top.sv =====
// DMI-over-JTAG master.
// i_item takes one request per cycle: a clock tick (action 0, with the sampled
// TDO) or an offered DMI request (action 1, with op, address and data).
// o_resp gives exactly one result per accepted request: the TCK/TMS/TDI/TRST_N
// pin values after it, whether an offered DMI request was latched, and on the
// tick that completes the read-back the DMI status flag and 32-bit data.
// i_cfg writes ir_length (index 0) and idle_ticks (index 1); it is always ready.
// Throughput: one request per cycle while the output is not stalled, set by the
// TAP step stage behind a 2-entry queue. A request passes through the queue
// and then the output register before its result is valid.
// Reset: TAP at test-logic-reset, pin state registers high, ir_length and
// idle_ticks at 5, queue and output register empty. The first 2*(idle_ticks+1)
// ticks walk the start-up sequence before a DMI request can be latched.
// Stall: the output register holds its result while o_resp.ready is low; the
// queue takes up to two more requests, after which i_item.ready drops.
`default_nettype none

module dmi_over_jtag_master_top #(
    parameter int DMI_WIDTH = dmij_pkg::DMI_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dmij_in_if.sink    i_item,
    dmij_cfg_if.sink   i_cfg,
    dmij_out_if.source o_resp
);

    dmij_pkg::t_q_src w_q;
    logic             w_pop;

    dmij_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_pop   (w_pop),
        .o_q     (w_q)
    );

    dmij_back #(
        .DMI_WIDTH (DMI_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (w_q),
        .o_pop   (w_pop),
        .i_cfg   (i_cfg),
        .o_resp  (o_resp)
    );

`ifndef SYNTHESIS
    a_reset_clears_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_resp.valid)
        else $error("output valid after reset");

    a_queue_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q.valid && (!o_resp.valid || o_resp.ready) |=> o_resp.valid)
        else $error("queued request not executed");

    a_full_means_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_item.ready |-> w_q.valid)
        else $error("input stalled with empty queue");
`endif

endmodule

`default_nettype wire
